// ===== hdl/tleb_pkg.sv =====
// ----------------------------------------------------------------------------
// tleb_pkg: shared types and constants for the longest-edge bisection block
// Default widths, configuration register indexes and reset values, and the
// helper that rounds a packed word up to whole bytes.
// ----------------------------------------------------------------------------
package tleb_pkg;

	// Default field widths of the block.
	localparam int COORD_BITS_DEF   = 24;
	localparam int NODE_ID_BITS_DEF = 16;

	// Configuration port shape.
	localparam int CFG_BITS      = 16;
	localparam int CFG_ADDR_BITS = 1;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_MIN_ANGLE_COS  = 1'b0,
		REG_FIRST_NEW_NODE = 1'b1
	} reg_idx_t;

	// Reset values of the configuration registers.
	localparam logic [CFG_BITS-1:0] MIN_ANGLE_COS_RST  = 16'd28378;
	localparam logic [CFG_BITS-1:0] FIRST_NEW_NODE_RST = 16'd0;

	// The cosine is Q1.15, so the squared test carries 2^30 on the left and a
	// factor of four on the right; both sides are divided by four.
	localparam int CMP_SHIFT = 28;

	// Bits needed for the squared cosine magnitude (at most 2^30).
	localparam int COS_SQ_BITS = 31;

	// Round a packed word width up to whole bytes.
	function automatic int byte_ceil(input int n);
		return ((n + 7) / 8) * 8;
	endfunction

endpackage

// ===== hdl/tleb_mul.sv =====
// ----------------------------------------------------------------------------
// tleb_mul: shared shift-and-add multiplier
// Retires one multiplier bit per cycle and stops early once the remaining
// multiplier bits are all zero. The product is held until the next start.
// ----------------------------------------------------------------------------
module tleb_mul #(
	parameter int P_W = 129,
	parameter int B_W = 50
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [P_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           done,
	output logic [P_W-1:0] prod
);

	logic           run_q;
	logic [P_W-1:0] mcand_q;
	logic [B_W-1:0] mplier_q;
	logic [P_W-1:0] acc_q;

	// The product is complete once no multiplier bits remain.
	assign done = run_q && (mplier_q == '0);
	assign prod = acc_q;

	// Busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (start) begin
			run_q <= 1'b1;
		end else if (done) begin
			run_q <= 1'b0;
		end
	end

	// One conditional add and one shift per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= a;
			mplier_q <= b;
			acc_q    <= '0;
		end else if (run_q && (mplier_q != '0)) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

// ===== hdl/triangle_longest_edge_bisect.sv =====
// ----------------------------------------------------------------------------
// triangle_longest_edge_bisect: minimum-angle test and longest-edge split
// Tests a triangle for an interior angle at or below a configured threshold
// and, if so, splits it at the midpoint of its longest edge.
// ----------------------------------------------------------------------------
// Usage:
// A triangle word enters on the s_ channel: three node ids and six vertex
// coordinates. Each triangle yields one or two words on the m_ channel.
// A passed-through triangle gives one word with tuser low and tlast high.
// A split triangle gives two words with tuser high and the new midpoint;
// tlast marks the second. The new node id is first_new_node plus the count
// of splits made so far, wrapping at the node id width.
// All arithmetic runs through one shift-and-add multiplier that retires one
// multiplier bit per cycle, so the work on one triangle is shorter when
// operands are small or an angle test settles on signs alone.
// s_tready is high only while no triangle is in work. The result sits in an
// output register, so a new triangle is taken while the last word of the
// previous one still waits; a stalled receiver holds the word and the block.
// Reset clears the split count and loads the register reset values.
// Configuration writes take effect at once, so they belong between
// triangles, while the block is idle.
// ----------------------------------------------------------------------------
module triangle_longest_edge_bisect #(
	parameter int COORD_BITS   = tleb_pkg::COORD_BITS_DEF,
	parameter int NODE_ID_BITS = tleb_pkg::NODE_ID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// id_a, id_b, id_c, xa, ya, xb, yb, xc, yc (lowest bits first)
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [tleb_pkg::byte_ceil(3*NODE_ID_BITS + 6*COORD_BITS)-1:0] s_tdata,
	// out_node_first, out_node_second, out_node_third, mid_x, mid_y
	output logic m_tvalid,
	input  logic m_tready,
	output logic [tleb_pkg::byte_ceil(3*NODE_ID_BITS + 2*COORD_BITS)-1:0] m_tdata,
	// refined
	output logic m_tuser,
	// is_last
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [tleb_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [tleb_pkg::CFG_BITS-1:0] cfg_wdata
);

	import tleb_pkg::*;

	localparam int C       = COORD_BITS;
	localparam int I       = NODE_ID_BITS;
	localparam int OUT_TDW = byte_ceil(3*I + 2*C);
	localparam int S_W     = 2*C + 1;
	localparam int N_W     = 2*C + 2;
	localparam int L_W     = 4*C + 4;
	localparam int T_W     = 2*C + COS_SQ_BITS + 1;
	localparam int P_W     = 4*C + COS_SQ_BITS + 2;
	localparam int MB_W    = 2*C + 2;
	localparam int SUM_W   = (I > CFG_BITS) ? I : CFG_BITS;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_ANGLE = 5'b00100,
		ST_EMIT1 = 5'b01000,
		ST_EMIT2 = 5'b10000
	} state_t;

	typedef enum logic [3:0] {
		OP_CM2, OP_DX1, OP_DY1, OP_DX2, OP_DY2, OP_DX3, OP_DY3, OP_NN, OP_T, OP_R
	} op_t;

	state_t state_q;
	op_t    op_q;
	logic   go_q;
	logic [1:0] ang_q;
	logic   flag_q;
	logic [I-1:0] split_q;
	logic [CFG_BITS-1:0] cos_q;
	logic [CFG_BITS-1:0] first_q;

	logic [I-1:0] ida_q, idb_q, idc_q;
	logic [C-1:0] xa_q, ya_q, xb_q, yb_q, xc_q, yc_q;
	logic [COS_SQ_BITS-1:0] cm2_q;
	logic [S_W-1:0] d1_q, d2_q, d3_q;
	logic [L_W-1:0] nn_q;
	logic [T_W-1:0] t_q;

	logic           m_tvalid_q;
	logic [OUT_TDW-1:0] odata_q;
	logic           ouser_q;
	logic           olast_q;

	logic in_acc, mul_take, out_free, out_load;
	logic cneg, cmag_zero, d_zero, nneg, hit;
	logic [CFG_BITS-1:0] cmag;
	logic [C-1:0] da, db, dmag;
	logic [C:0] ddiff;
	logic [S_W-1:0] opp, s1, s2;
	logic [N_W-1:0] psum, nmag;
	logic [P_W-1:0] mul_a, lhs, prod;
	logic [MB_W-1:0] mul_b;
	logic mul_done;
	logic [SUM_W-1:0] nid_sum;
	logic [I-1:0] nid, n1, n2, n3;
	logic e_ab, e_bc;
	logic [C-1:0] pa_x, pb_x, pa_y, pb_y, mx, my;
	logic [C:0] sx, sy;
	logic wlast;

	// Handshake strobes.
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign mul_take = (state_q == ST_MUL) && mul_done && !go_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && ((state_q == ST_EMIT1) || (state_q == ST_EMIT2));

	// Threshold sign and magnitude.
	assign cneg      = cos_q[CFG_BITS-1];
	assign cmag      = cneg ? (CFG_BITS'(0) - cos_q) : cos_q;
	assign cmag_zero = (cmag == '0);

	// Absolute coordinate difference for the square being formed.
	always_comb begin
		case (op_q)
			OP_DX1:  begin da = xa_q; db = xb_q; end
			OP_DY1:  begin da = ya_q; db = yb_q; end
			OP_DX2:  begin da = xb_q; db = xc_q; end
			OP_DY2:  begin da = yb_q; db = yc_q; end
			OP_DX3:  begin da = xc_q; db = xa_q; end
			OP_DY3:  begin da = yc_q; db = ya_q; end
			default: begin da = '0;   db = '0;   end
		endcase
		ddiff = {da[C-1], da} - {db[C-1], db};
		dmag  = ddiff[C] ? C'(-ddiff) : ddiff[C-1:0];
	end

	// Squared sides seen from the angle under test.
	always_comb begin
		case (ang_q)
			2'd0:    begin opp = d1_q; s1 = d2_q; s2 = d3_q; end
			2'd1:    begin opp = d2_q; s1 = d1_q; s2 = d3_q; end
			2'd2:    begin opp = d3_q; s1 = d1_q; s2 = d2_q; end
			default: begin opp = d1_q; s1 = d2_q; s2 = d3_q; end
		endcase
		psum = {1'b0, s1} + {1'b0, s2};
		nneg = psum < {1'b0, opp};
		nmag = nneg ? ({1'b0, opp} - psum) : (psum - {1'b0, opp});
	end

	assign d_zero = (d1_q == '0) || (d2_q == '0) || (d3_q == '0);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (op_q)
			OP_CM2:  begin mul_a = P_W'(cmag);  mul_b = MB_W'(cmag); end
			OP_DX1, OP_DY1, OP_DX2, OP_DY2, OP_DX3, OP_DY3: begin
				mul_a = P_W'(dmag);
				mul_b = MB_W'(dmag);
			end
			OP_NN:   begin mul_a = P_W'(nmag);  mul_b = MB_W'(nmag); end
			OP_T:    begin mul_a = P_W'(cm2_q); mul_b = MB_W'(s1);   end
			OP_R:    begin mul_a = P_W'(t_q);   mul_b = MB_W'(s2);   end
			default: begin mul_a = '0;          mul_b = '0;          end
		endcase
	end

	tleb_mul #(
		.P_W(P_W),
		.B_W(MB_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (go_q),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (prod)
	);

	// Squared comparison: N^2 * 2^28 against cos^2 * s1 * s2.
	assign lhs = P_W'({nn_q, {CMP_SHIFT{1'b0}}});
	assign hit = nneg ? (lhs <= prod) : (lhs >= prod);

	// Sequencer and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_CM2;
			go_q    <= 1'b0;
			ang_q   <= 2'd0;
			flag_q  <= 1'b0;
			split_q <= '0;
			cos_q   <= MIN_ANGLE_COS_RST;
			first_q <= FIRST_NEW_NODE_RST;
		end else begin
			go_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_addr)
					REG_MIN_ANGLE_COS:  cos_q   <= cfg_wdata;
					REG_FIRST_NEW_NODE: first_q <= cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q    <= OP_CM2;
						go_q    <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_take) begin
						case (op_q)
							OP_CM2: begin op_q <= OP_DX1; go_q <= 1'b1; end
							OP_DX1: begin op_q <= OP_DY1; go_q <= 1'b1; end
							OP_DY1: begin op_q <= OP_DX2; go_q <= 1'b1; end
							OP_DX2: begin op_q <= OP_DY2; go_q <= 1'b1; end
							OP_DY2: begin op_q <= OP_DX3; go_q <= 1'b1; end
							OP_DX3: begin op_q <= OP_DY3; go_q <= 1'b1; end
							OP_DY3: begin
								ang_q   <= 2'd0;
								state_q <= ST_ANGLE;
							end
							OP_NN:  begin op_q <= OP_T; go_q <= 1'b1; end
							OP_T:   begin op_q <= OP_R; go_q <= 1'b1; end
							OP_R: begin
								if (hit) begin
									flag_q  <= 1'b1;
									state_q <= ST_EMIT1;
								end else if (ang_q == 2'd2) begin
									flag_q  <= 1'b0;
									state_q <= ST_EMIT1;
								end else begin
									ang_q   <= ang_q + 2'd1;
									state_q <= ST_ANGLE;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ANGLE: begin
					if (d_zero) begin
						// A degenerate side is never refined.
						flag_q  <= 1'b0;
						state_q <= ST_EMIT1;
					end else if (!nneg && (cneg || cmag_zero)) begin
						flag_q  <= 1'b1;
						state_q <= ST_EMIT1;
					end else if (nneg && !cneg) begin
						if (ang_q == 2'd2) begin
							flag_q  <= 1'b0;
							state_q <= ST_EMIT1;
						end else begin
							ang_q <= ang_q + 2'd1;
						end
					end else begin
						op_q    <= OP_NN;
						go_q    <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						state_q <= flag_q ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						split_q <= split_q + I'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Triangle capture and multiplier results.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ida_q <= s_tdata[0 +: I];
			idb_q <= s_tdata[I +: I];
			idc_q <= s_tdata[2*I +: I];
			xa_q  <= s_tdata[3*I +: C];
			ya_q  <= s_tdata[3*I + C +: C];
			xb_q  <= s_tdata[3*I + 2*C +: C];
			yb_q  <= s_tdata[3*I + 3*C +: C];
			xc_q  <= s_tdata[3*I + 4*C +: C];
			yc_q  <= s_tdata[3*I + 5*C +: C];
		end
		if (mul_take) begin
			case (op_q)
				OP_CM2:  cm2_q <= prod[COS_SQ_BITS-1:0];
				OP_DX1:  d1_q  <= prod[S_W-1:0];
				OP_DY1:  d1_q  <= d1_q + prod[S_W-1:0];
				OP_DX2:  d2_q  <= prod[S_W-1:0];
				OP_DY2:  d2_q  <= d2_q + prod[S_W-1:0];
				OP_DX3:  d3_q  <= prod[S_W-1:0];
				OP_DY3:  d3_q  <= d3_q + prod[S_W-1:0];
				OP_NN:   nn_q  <= prod[L_W-1:0];
				OP_T:    t_q   <= prod[T_W-1:0];
				default: ;
			endcase
		end
	end

	// Longest edge (first wins on ties), new node id and midpoint.
	assign e_ab    = (d1_q >= d2_q) && (d1_q >= d3_q);
	assign e_bc    = !e_ab && (d2_q >= d3_q);
	assign nid_sum = SUM_W'(first_q) + SUM_W'(split_q);
	assign nid     = nid_sum[I-1:0];

	always_comb begin
		if (e_ab) begin
			pa_x = xa_q; pb_x = xb_q; pa_y = ya_q; pb_y = yb_q;
		end else if (e_bc) begin
			pa_x = xb_q; pb_x = xc_q; pa_y = yb_q; pb_y = yc_q;
		end else begin
			pa_x = xc_q; pb_x = xa_q; pa_y = yc_q; pb_y = ya_q;
		end
		sx = {pa_x[C-1], pa_x} + {pb_x[C-1], pb_x};
		sy = {pa_y[C-1], pa_y} + {pb_y[C-1], pb_y};
	end

	// Word to emit: pass-through, or one half of the split.
	always_comb begin
		n1 = ida_q;
		n2 = idb_q;
		n3 = idc_q;
		mx = '0;
		my = '0;
		wlast = 1'b1;
		if (flag_q) begin
			mx    = sx[C:1];
			my    = sy[C:1];
			wlast = (state_q == ST_EMIT2);
			if (state_q == ST_EMIT2) begin
				if (e_ab) begin
					n1 = nid;
				end else begin
					n3 = nid;
				end
			end else begin
				if (e_ab || e_bc) begin
					n2 = nid;
				end else begin
					n1 = nid;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= OUT_TDW'({my, mx, n3, n2, n1});
			ouser_q <= flag_q;
			olast_q <= wlast;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;
	assign m_tlast  = olast_q;

endmodule

// ===== hdl/tleb_chk.sv =====
// ----------------------------------------------------------------------------
// tleb_chk: port-level checks for the longest-edge bisection block
// Watches the stream ports for word ordering and field rules over time.
// ----------------------------------------------------------------------------
module tleb_chk #(
	parameter int COORD_BITS   = tleb_pkg::COORD_BITS_DEF,
	parameter int NODE_ID_BITS = tleb_pkg::NODE_ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [tleb_pkg::byte_ceil(3*NODE_ID_BITS + 2*COORD_BITS)-1:0] m_tdata,
	input logic m_tuser,
	input logic m_tlast
);

	import tleb_pkg::*;

	logic [2*COORD_BITS-1:0] mid;

	assign mid = m_tdata[3*NODE_ID_BITS +: 2*COORD_BITS];

	// A stalled word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output word changed");

	// A pass-through triangle is a single word.
	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("pass-through word without tlast");

	// A pass-through triangle carries no midpoint.
	a_pass_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (mid == '0))
		else $error("pass-through word with non-zero midpoint");

	// The second half of a split follows at once with the same midpoint.
	a_split_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=>
			m_tvalid && m_tuser && m_tlast && (mid == $past(mid)))
		else $error("split pair broken");

	// One triangle at a time: busy right after taking one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a triangle is in work");

endmodule

bind triangle_longest_edge_bisect tleb_chk #(
	.COORD_BITS  (COORD_BITS),
	.NODE_ID_BITS(NODE_ID_BITS)
) u_tleb_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
